@@ hdl/lay_pkg.sv @@
// Shared types, constants and rounding helpers for the look-at yaw/pitch pipeline.
package lay_pkg;

	// One input item: object and camera positions, signed Q16.16
	typedef struct packed {
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
		logic signed [31:0] obj_z;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
	} lay_in_t;

	// One result item: angles in signed fixed-point radians
	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [14:0] pitch_angle;
	} lay_out_t;

	localparam int DW        = 33;	// difference / magnitude width
	localparam int CW        = 63;	// CORDIC x/y datapath width
	localparam int SQW       = 63;	// radicand width
	localparam int SQ_STEPS  = 32;	// root bits
	localparam int PRESCALE  = 26;
	localparam int NORM_TOP  = 30;	// largest magnitude lands in [2^30, 2^31)
	localparam int NW        = 31;	// normalized magnitude width
	localparam int ATAN_ENTRIES = 22;

	// atan(2^-i) in Q32, truncated; small angles sit just below a power of two
	localparam logic [63:0] ATAN_Q32 [0:ATAN_ENTRIES-1] = '{
		64'd3373259426, 64'd1991351317, 64'd1052175346, 64'd534100634,
		64'd268086747,  64'd134174062,  64'd67103403,   64'd33553749,
		64'd16777130,   64'd8388597,    64'd4194302,    64'd2097151,
		64'd1048575,    64'd524287,     64'd262143,     64'd131071,
		64'd65535,      64'd32767,      64'd16383,      64'd8191,
		64'd4095,       64'd2047
	};
	localparam logic [63:0] QPI_Q32 = 64'd3373259426;

	// Yaw chain sideband
	typedef struct packed {
		logic zero_y;
		logic zero_x;
		logic neg_z;
		logic neg_x;
	} lay_yaw_sb_t;

	// Root chain sideband
	typedef struct packed {
		logic [NW-1:0] y_mag;
		logic          pos_y;
	} lay_sq_sb_t;

	// Pitch chain sideband
	typedef struct packed {
		logic zero_y;
		logic zero_x;
		logic pos_y;
	} lay_pit_sb_t;

	// Round a Q32 value half-up to frac fraction bits
	function automatic logic [31:0] round_q32(input logic [63:0] v, input int frac);
		logic [63:0] s;
		s = v + (64'd1 << (31 - frac));
		return s[63:32] == 32'd0 ? 32'(s >> (32 - frac)) : 32'(s >> (32 - frac));
	endfunction

	// Position of the leading one, zero for a zero word
	function automatic logic [5:0] lead_pos(input logic [DW-1:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < DW; i++) begin
			if (m[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

@@ hdl/lay_sqrt_cell.sv @@
// One digit step of the pipelined floor square root.
module lay_sqrt_cell #(
	parameter int IDX = 0,
	parameter int SW  = 1
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [lay_pkg::SQW-1:0]  v_i,
	input  logic [lay_pkg::SQW-1:0]  r_i,
	input  logic [SW-1:0]            sb_i,
	output logic [lay_pkg::SQW-1:0]  v_o,
	output logic [lay_pkg::SQW-1:0]  r_o,
	output logic [SW-1:0]            sb_o
);
	import lay_pkg::*;

	localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 1 - 2 * IDX);

	logic [SQW:0] trial;
	logic         fits;

	assign trial = {1'b0, r_i} + {1'b0, BIT};
	assign fits  = {1'b0, v_i} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			if (fits) begin
				v_o <= v_i - trial[SQW-1:0];
				r_o <= (r_i >> 1) + BIT;
			end else begin
				v_o <= v_i;
				r_o <= r_i >> 1;
			end
			sb_o <= sb_i;
		end
	end

endmodule

@@ hdl/lay_cordic_cell.sv @@
// One vectoring micro-rotation of the pipelined CORDIC.
module lay_cordic_cell #(
	parameter int IDX  = 0,
	parameter int FRAC = 13,
	parameter int SW   = 1
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [lay_pkg::CW-1:0]  x_i,
	input  logic signed [lay_pkg::CW-1:0]  y_i,
	input  logic signed [FRAC+2:0]         z_i,
	input  logic [SW-1:0]                  sb_i,
	output logic signed [lay_pkg::CW-1:0]  x_o,
	output logic signed [lay_pkg::CW-1:0]  y_o,
	output logic signed [FRAC+2:0]         z_o,
	output logic [SW-1:0]                  sb_o
);
	import lay_pkg::*;

	localparam logic signed [FRAC+2:0] ATAN_Q = (FRAC + 3)'(round_q32(ATAN_Q32[IDX], FRAC));

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[CW-1]) begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + ATAN_Q;
			end else begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - ATAN_Q;
			end
			sb_o <= sb_i;
		end
	end

endmodule

@@ hdl/look_at_yaw_pitch.sv @@
// Look-at angles: yaw = atan2(dx, dz), pitch = -atan2(dy, hypot(dx, dz)) from two positions.
// Fully pipelined, one item per cycle while the output is not stalled: two stages form the
// differences and magnitudes, five normalize and square the horizontal components, a chain
// of 32 root cells takes the floor square root one bit per cell, a chain of ANGLE_FRAC_BITS
// + 2 CORDIC cells finds the pitch angle, and one stage clamps and signs it; that final
// register is the output register. Yaw runs through its own CORDIC chain in parallel and
// waits in a delay line to meet its pitch. The whole pipe advances whenever the output
// register is empty or being taken, so query_ready follows angles_ready and bubbles drain
// without blocking new items. Angles are signed radians with ANGLE_FRAC_BITS fraction bits,
// masked to 16 bits (yaw) and 15 bits (pitch); those widths hold the full range up to 13
// fraction bits. Equal positions give both angles zero.
module look_at_yaw_pitch #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_ready,
	input  lay_pkg::lay_in_t  query,
	output logic              angles_valid,
	input  logic              angles_ready,
	output lay_pkg::lay_out_t angles
);
	import lay_pkg::*;

	localparam int N    = ANGLE_FRAC_BITS + 2;		// micro-rotations per chain
	localparam int ZW   = ANGLE_FRAC_BITS + 3;		// angle accumulator width
	localparam int YF   = N + 3;				// stage of the finished yaw
	localparam int LAT  = N + SQ_STEPS + 8;		// stage of the output register
	localparam int YDLY = LAT - YF;

	localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(round_q32(QPI_Q32 << 1, ANGLE_FRAC_BITS));
	localparam logic signed [ZW-1:0] PI_Q      = ZW'(round_q32(QPI_Q32 << 2, ANGLE_FRAC_BITS));

	// Angle of a first-quadrant vector from the chain result, with axis cases
	function automatic logic signed [ZW-1:0] fold_angle(input logic signed [ZW-1:0] z,
			input logic zy, input logic zx);
		logic signed [ZW-1:0] a;
		priority if (zy) a = '0;
		else if (zx) a = HALF_PI_Q;
		else if (z < 0) a = '0;
		else if (z > HALF_PI_Q) a = HALF_PI_Q;
		else a = z;
		return a;
	endfunction

	// ---------------------------------------------------------------- flow control
	logic           adv;
	logic [LAT:1]   vld_q;

	assign adv          = !vld_q[LAT] || angles_ready;
	assign query_ready  = adv;
	assign angles_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-1:1], query_valid};
		end
	end

	// ---------------------------------------------------------------- differences
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [DW-1:0]        ax_s2, ay_s2, az_s2;
	logic                 neg_x_s2, pos_y_s2, neg_z_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DW'(query.obj_x) - DW'(query.cam_x);
			dy_s1 <= DW'(query.obj_y) - DW'(query.cam_y);
			dz_s1 <= DW'(query.obj_z) - DW'(query.cam_z);
			// magnitude of -2^32 wraps to the right unsigned pattern
			ax_s2    <= dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
			ay_s2    <= dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
			az_s2    <= dz_s1[DW-1] ? DW'(-dz_s1) : DW'(dz_s1);
			neg_x_s2 <= dx_s1[DW-1];
			pos_y_s2 <= !dy_s1[DW-1] && (dy_s1 != '0);
			neg_z_s2 <= dz_s1[DW-1];
		end
	end

	// ---------------------------------------------------------------- yaw chain
	logic signed [CW-1:0] yx [0:N];
	logic signed [CW-1:0] yy [0:N];
	logic signed [ZW-1:0] yz [0:N];
	lay_yaw_sb_t          ysb [0:N];

	assign yx[0]  = CW'(az_s2) << PRESCALE;
	assign yy[0]  = CW'(ax_s2) << PRESCALE;
	assign yz[0]  = '0;
	assign ysb[0] = '{zero_y: (ax_s2 == '0), zero_x: (az_s2 == '0),
			neg_z: neg_z_s2, neg_x: neg_x_s2};

	for (genvar i = 0; i < N; i++) begin : g_yaw
		lay_cordic_cell #(.IDX(i), .FRAC(ANGLE_FRAC_BITS), .SW($bits(lay_yaw_sb_t))) u_cell (
			.clk  (clk),
			.en   (adv),
			.x_i  (yx[i]),
			.y_i  (yy[i]),
			.z_i  (yz[i]),
			.sb_i (ysb[i]),
			.x_o  (yx[i+1]),
			.y_o  (yy[i+1]),
			.z_o  (yz[i+1]),
			.sb_o (ysb[i+1])
		);
	end

	// quadrant fix-up: back half-plane mirrors about pi/2, negative x flips sign
	logic signed [ZW-1:0] yaw_a, yaw_h, yaw_v;
	logic signed [31:0]   yaw_w;
	logic [15:0]          yaw_dly_q [0:YDLY];

	assign yaw_a = fold_angle(yz[N], ysb[N].zero_y, ysb[N].zero_x);
	assign yaw_h = ysb[N].neg_z ? PI_Q - yaw_a : yaw_a;
	assign yaw_v = ysb[N].neg_x ? -yaw_h : yaw_h;
	assign yaw_w = 32'(yaw_v);

	always_ff @(posedge clk) begin
		if (adv) begin
			yaw_dly_q[0] <= yaw_w[15:0];
			for (int k = 1; k <= YDLY; k++) begin
				yaw_dly_q[k] <= yaw_dly_q[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- normalize, square
	logic [DW-1:0]   m_s3, ax_s3, ay_s3, az_s3;
	logic            pos_y_s3, pos_y_s4, pos_y_s5, pos_y_s6, pos_y_s7;
	logic [5:0]      p_s4;
	logic [DW-1:0]   ax_s4, ay_s4, az_s4;
	logic [NW-1:0]   xn_s5, yn_s5, zn_s5, yn_s6, yn_s7;
	logic [2*NW-1:0] xx_s6, zz_s6;
	logic [SQW-1:0]  v_s7;
	logic [DW-1:0]   mxz;
	logic [SQW-1:0]  xsh, ysh, zsh;

	assign mxz = (ax_s2 > az_s2) ? ax_s2 : az_s2;
	// floor(a * 2^30 / 2^p) equals the exact left / truncating right normalization
	assign xsh = {ax_s4, NORM_TOP'(0)} >> p_s4;
	assign ysh = {ay_s4, NORM_TOP'(0)} >> p_s4;
	assign zsh = {az_s4, NORM_TOP'(0)} >> p_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3     <= (ay_s2 > mxz) ? ay_s2 : mxz;
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			az_s3    <= az_s2;
			pos_y_s3 <= pos_y_s2;

			p_s4     <= lead_pos(m_s3);
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			az_s4    <= az_s3;
			pos_y_s4 <= pos_y_s3;

			xn_s5    <= xsh[NW-1:0];
			yn_s5    <= ysh[NW-1:0];
			zn_s5    <= zsh[NW-1:0];
			pos_y_s5 <= pos_y_s4;

			xx_s6    <= xn_s5 * xn_s5;
			zz_s6    <= zn_s5 * zn_s5;
			yn_s6    <= yn_s5;
			pos_y_s6 <= pos_y_s5;

			v_s7     <= SQW'(xx_s6) + SQW'(zz_s6);
			yn_s7    <= yn_s6;
			pos_y_s7 <= pos_y_s6;
		end
	end

	// ---------------------------------------------------------------- root chain
	logic [SQW-1:0] sv [0:SQ_STEPS];
	logic [SQW-1:0] sr [0:SQ_STEPS];
	lay_sq_sb_t     ssb [0:SQ_STEPS];

	assign sv[0]  = v_s7;
	assign sr[0]  = '0;
	assign ssb[0] = '{y_mag: yn_s7, pos_y: pos_y_s7};

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_root
		lay_sqrt_cell #(.IDX(k), .SW($bits(lay_sq_sb_t))) u_cell (
			.clk  (clk),
			.en   (adv),
			.v_i  (sv[k]),
			.r_i  (sr[k]),
			.sb_i (ssb[k]),
			.v_o  (sv[k+1]),
			.r_o  (sr[k+1]),
			.sb_o (ssb[k+1])
		);
	end

	// ---------------------------------------------------------------- pitch chain
	logic [31:0]          h_root;
	logic signed [CW-1:0] px [0:N];
	logic signed [CW-1:0] py [0:N];
	logic signed [ZW-1:0] pz [0:N];
	lay_pit_sb_t          psb [0:N];

	assign h_root = sr[SQ_STEPS][31:0];
	assign px[0]  = CW'(h_root) << PRESCALE;
	assign py[0]  = CW'(ssb[SQ_STEPS].y_mag) << PRESCALE;
	assign pz[0]  = '0;
	assign psb[0] = '{zero_y: (ssb[SQ_STEPS].y_mag == '0), zero_x: (h_root == '0),
			pos_y: ssb[SQ_STEPS].pos_y};

	for (genvar i = 0; i < N; i++) begin : g_pitch
		lay_cordic_cell #(.IDX(i), .FRAC(ANGLE_FRAC_BITS), .SW($bits(lay_pit_sb_t))) u_cell (
			.clk  (clk),
			.en   (adv),
			.x_i  (px[i]),
			.y_i  (py[i]),
			.z_i  (pz[i]),
			.sb_i (psb[i]),
			.x_o  (px[i+1]),
			.y_o  (py[i+1]),
			.z_o  (pz[i+1]),
			.sb_o (psb[i+1])
		);
	end

	// looking up (dy > 0) is a negative pitch
	logic signed [ZW-1:0] pit_a, pit_v;
	logic signed [31:0]   pit_w;
	logic [14:0]          pitch_q;

	assign pit_a = fold_angle(pz[N], psb[N].zero_y, psb[N].zero_x);
	assign pit_v = psb[N].pos_y ? -pit_a : pit_a;
	assign pit_w = 32'(pit_v);

	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_q <= pit_w[14:0];
		end
	end

	assign angles = '{yaw_angle: yaw_dly_q[YDLY], pitch_angle: pitch_q};

endmodule

@@ hdl/lay_chk.sv @@
// Port-level checks for look_at_yaw_pitch, bound to the top level.
module lay_chk #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic              clk,
	input logic              arst_n,
	input logic              query_valid,
	input logic              query_ready,
	input lay_pkg::lay_in_t  query,
	input logic              angles_valid,
	input logic              angles_ready,
	input lay_pkg::lay_out_t angles
);
	import lay_pkg::*;

	localparam logic signed [15:0] YAW_LIM   = 16'sd25736;
	localparam logic signed [14:0] PITCH_LIM = 15'sd12868;
	localparam bit                 FULL_RANGE = (ANGLE_FRAC_BITS == 13);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && !angles_ready |=> angles_valid && $stable(angles))
		else $error("result item changed while stalled");

	// the pipe never blocks input while the output is being drained
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		angles_ready |-> query_ready)
		else $error("input stalled with output ready");

	// an accepted item carries a known payload
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && query_ready |-> !$isunknown(query))
		else $error("accepted item has unknown bits");

	a_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && FULL_RANGE |->
			angles.yaw_angle >= -YAW_LIM && angles.yaw_angle <= YAW_LIM)
		else $error("yaw outside [-pi, pi]");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && FULL_RANGE |->
			angles.pitch_angle >= -PITCH_LIM && angles.pitch_angle <= PITCH_LIM)
		else $error("pitch outside [-pi/2, pi/2]");

endmodule

bind look_at_yaw_pitch lay_chk #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lay_chk (.*);

@@ dv/tb.sv @@
// Testbench for look_at_yaw_pitch: directed and random items checked against a bit-exact angle predictor.
`timescale 1ns / 1ps

module tb;
	import lay_pkg::*;

	localparam int FRAC       = 13;
	localparam int ROTATIONS  = FRAC + 2;
	localparam int PRE_SHIFT  = 26;
	localparam int PIPE_DEPTH = FRAC + 42;	// equals LAT, the stage of the design's output register

	logic     clk;
	logic     arst_n;
	logic     query_valid;
	logic     query_ready;
	lay_in_t  query;
	logic     angles_valid;
	logic     angles_ready;
	lay_out_t angles;

	look_at_yaw_pitch #(.ANGLE_FRAC_BITS(FRAC)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.angles_valid (angles_valid),
		.angles_ready (angles_ready),
		.angles       (angles)
	);

	// Angle constants in Q(FRAC), built from Q60 arctangent series
	longint atan_q [0:ROTATIONS-1];
	longint pi_q;
	longint half_pi_q;

	lay_out_t angles_due [$];	// predicted angles, oldest first
	int       err_count;
	int       send_idle_pct;	// chance per cycle that the sender holds off
	int       recv_stall_pct;	// chance per cycle that the receiver stalls
	int       hold_cycles;	// long receiver hold-off, counted down below

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Global watchdog
	initial begin
		#5_000_000;
		$display("** look_at_yaw_pitch: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// atan(1/d) in Q60 by the alternating series, truncating each term
	function automatic longint unsigned atan_recip(input longint unsigned d);
		longint unsigned term, sum, dd, k, c;
		bit              neg;
		term = (64'd1 << 60) / d;
		sum  = term;
		dd   = d * d;
		k    = 1;
		neg  = 1'b1;
		forever begin
			term = term / dd;
			if (term == 0) break;
			c   = term / (2 * k + 1);
			sum = neg ? sum - c : sum + c;
			neg = !neg;
			k++;
		end
		return sum;
	endfunction

	function automatic longint q60_round(input longint unsigned v);
		return longint'((v + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
	endfunction

	task automatic build_angle_table();
		longint unsigned quarter;
		quarter   = 4 * atan_recip(5) - atan_recip(239);
		atan_q[0] = q60_round(quarter);
		for (int i = 1; i < ROTATIONS; i++)
			atan_q[i] = q60_round(atan_recip(64'd1 << i));
		pi_q      = q60_round(4 * quarter);
		half_pi_q = q60_round(2 * quarter);
	endtask

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// First-quadrant angle of (x0, y0) by vectoring CORDIC, clamped to [0, pi/2]
	function automatic longint quadrant_angle(input longint unsigned x0, input longint unsigned y0);
		longint x, y, z, xs, ys;
		if (y0 == 0) return 0;
		if (x0 == 0) return half_pi_q;
		x = longint'(x0 << PRE_SHIFT);
		y = longint'(y0 << PRE_SHIFT);
		z = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_q[i];
			end else begin
				x -= ys; y += xs; z -= atan_q[i];
			end
		end
		if (z < 0) z = 0;
		if (z > half_pi_q) z = half_pi_q;
		return z;
	endfunction

	function automatic lay_out_t look_angles(input lay_in_t q);
		longint          dx, dy, dz, yaw, pitch, a;
		longint unsigned ax, ay, az, m, nx, ny, nz, h;
		int              l, r;
		lay_out_t        res;
		dx = longint'(q.obj_x) - longint'(q.cam_x);
		dy = longint'(q.obj_y) - longint'(q.cam_y);
		dz = longint'(q.obj_z) - longint'(q.cam_z);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		yaw   = 0;
		pitch = 0;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		if (m != 0) begin
			if (ax != 0 || az != 0) begin
				a   = quadrant_angle(az, ax);
				yaw = (dz >= 0) ? a : pi_q - a;
				if (dx < 0) yaw = -yaw;
			end
			// common power-of-two scale puts the largest magnitude in [2^30, 2^31)
			l = 0;
			r = 0;
			while ((m << l) < (64'd1 << 30)) l++;
			while ((m >> r) >= (64'd1 << 31)) r++;
			nx = (ax << l) >> r;
			ny = (ay << l) >> r;
			nz = (az << l) >> r;
			h  = floor_sqrt(nx * nx + nz * nz);
			a  = quadrant_angle(h, ny);
			pitch = (dy > 0) ? -a : a;
		end
		res.yaw_angle   = yaw[15:0];
		res.pitch_angle = pitch[14:0];
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Driving and checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Offers one item with random idle cycles ahead of it; returns once taken
	task automatic send_query(input lay_in_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query_valid <= 1'b1;
		query       <= q;
		do @(posedge clk); while (!query_ready);
		angles_due.push_back(look_angles(q));
	endtask

	task automatic wait_drained();
		query_valid <= 1'b0;
		wait (angles_due.size() == 0);
		@(posedge clk);
	endtask

	// Long receiver hold-off counter
	always @(posedge clk) begin
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	// Result checker and receiver stall generator
	always @(posedge clk) begin
		lay_out_t want;
		if (arst_n && angles_valid && angles_ready) begin
			if (angles_due.size() == 0) begin
				report_mismatch($sformatf("unexpected item yaw=%0d pitch=%0d",
					angles.yaw_angle, angles.pitch_angle));
			end else begin
				want = angles_due.pop_front();
				if (angles.yaw_angle !== want.yaw_angle)
					report_mismatch($sformatf("yaw got %0d want %0d",
						angles.yaw_angle, want.yaw_angle));
				if (angles.pitch_angle !== want.pitch_angle)
					report_mismatch($sformatf("pitch got %0d want %0d",
						angles.pitch_angle, want.pitch_angle));
			end
		end
		angles_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	function automatic lay_in_t make_query(input int ox, oy, oz, cx, cy, cz);
		lay_in_t q;
		q.obj_x = ox; q.obj_y = oy; q.obj_z = oz;
		q.cam_x = cx; q.cam_y = cy; q.cam_z = cz;
		return q;
	endfunction

	// Random item: mostly nearby objects, some anywhere, some with axes zeroed
	function automatic lay_in_t random_query();
		lay_in_t q;
		int      span;
		q.cam_x = $urandom; q.cam_y = $urandom; q.cam_z = $urandom;
		case ($urandom_range(3))
			0: begin
				q.obj_x = $urandom; q.obj_y = $urandom; q.obj_z = $urandom;
			end
			default: begin
				span    = 1 << $urandom_range(30);
				q.obj_x = q.cam_x + $signed($urandom_range(2 * span) - span);
				q.obj_y = q.cam_y + $signed($urandom_range(2 * span) - span);
				q.obj_z = q.cam_z + $signed($urandom_range(2 * span) - span);
			end
		endcase
		if ($urandom_range(9) == 0) q.obj_x = q.cam_x;
		if ($urandom_range(9) == 0) q.obj_y = q.cam_y;
		if ($urandom_range(9) == 0) q.obj_z = q.cam_z;
		return q;
	endfunction

	localparam int MAXP = 32'h7fffffff;
	localparam int MINN = 32'h80000000;

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_query(make_query(0, 0, 0, 0, 0, 0));	// zero difference
		send_query(make_query(5, 5, 5, 5, 5, 5));
		send_query(make_query(MAXP, MAXP, MAXP, MINN, MINN, MINN));	// largest positive d
		send_query(make_query(MINN, MINN, MINN, MAXP, MAXP, MAXP));	// largest negative d
		send_query(make_query(0, 1, 0, 0, 0, 0));	// straight up
		send_query(make_query(0, -1, 0, 0, 0, 0));	// straight down
		send_query(make_query(0, MAXP, 0, 0, MINN, 0));
		send_query(make_query(1, 0, 0, 0, 0, 0));	// level, along +x
		send_query(make_query(-1, 0, 0, 0, 0, 0));
		send_query(make_query(0, 0, 1, 0, 0, 0));	// dead ahead
		send_query(make_query(0, 0, -1, 0, 0, 0));	// directly behind, yaw = pi
		send_query(make_query(1, 0, -1, 0, 0, 0));
		send_query(make_query(-1, 0, -1, 0, 0, 0));
		send_query(make_query(1, 1, 1, 0, 0, 0));
		send_query(make_query(-1, -1, 1, 0, 0, 0));
		send_query(make_query(65536, -65536, -65536, 0, 0, 0));
		send_query(make_query(MAXP, 0, 1, MINN, 0, 0));
		send_query(make_query(1, 0, MAXP, 0, 0, MINN));
		send_query(make_query(MINN, 1, 0, 0, 0, 0));
		send_query(make_query(3, MAXP, 2, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) send_query(random_query());
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 3 * PIPE_DEPTH;
		for (int i = 0; i < 2 * PIPE_DEPTH; i++) send_query(random_query());
		wait_drained();	// sender pauses until all angles are back
	endtask

	initial begin
		err_count      = 0;
		hold_cycles    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		query_valid    = 1'b0;
		query          = '0;
		angles_ready   = 1'b0;
		build_angle_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(0, 0, 100);
		test_random_phase(79, 0, 80);
		test_random_phase(0, 79, 80);
		test_random_phase(37, 37, 80);
		test_backpressure();
		test_random_phase(0, 0, 20);

		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (angles_due.size() != 0)
			report_mismatch($sformatf("%0d items never came out", angles_due.size()));
		if (err_count == 0) begin
			$display("** look_at_yaw_pitch: PASSED **");
		end else begin
			$display("** look_at_yaw_pitch: FAILED **");
		end
		$finish;
	end

endmodule
